// File: design/isaf_pkg.sv
// shared types and constants for the inverse-square attractor force core
package isaf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W = 32;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 31;

    localparam logic [DATA_W-1:0] RANGE_RESET = DATA_W'(64'd2 << FRAC_BITS);
    localparam logic [DATA_W-1:0] STRENGTH_RESET = DATA_W'(64'd10 << FRAC_BITS);

    // register word indexes
    localparam logic REG_RANGE = 1'b0;
    localparam logic REG_STRENGTH = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] source_x;
        logic signed [DATA_W-1:0] source_y;
        logic signed [DATA_W-1:0] source_z;
        logic signed [DATA_W-1:0] body_x;
        logic signed [DATA_W-1:0] body_y;
        logic signed [DATA_W-1:0] body_z;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic                     in_range;
    } out_item_t;

    // one step of the square root chain
    typedef struct packed {
        logic                   valid;
        logic [63:0]            rem;
        logic [31:0]            root;
        logic [63:0]            s;
        logic                   ok;
        logic [2:0]             neg;
        logic [2:0][31:0]       mag;
    } sq_stage_t;

    // one step of the three-lane divider chain
    typedef struct packed {
        logic                   valid;
        logic                   ok;
        logic [2:0]             neg;
        logic [2:0]             sat;
        logic [126:0]           dsh;
        logic [2:0][127:0]      rem;
        logic [2:0][30:0]       quo;
    } div_stage_t;

endpackage

// File: design/isaf_sqrt_cell.sv
// one bit of the digit-by-digit integer square root
module isaf_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  isaf_pkg::sq_stage_t stage_in,
    output isaf_pkg::sq_stage_t stage_out
);
    import isaf_pkg::*;

    sq_stage_t   stage_reg;
    sq_stage_t   stage_next;
    logic [65:0] trial;
    logic        take;

    // (root + 2^bit)^2 - root^2 against the remaining radicand
    always_comb begin
        stage_next = stage_in;
        trial = ({34'd0, stage_in.root} << (BIT + 1)) + (66'd1 << (2 * BIT));
        take = ({2'b00, stage_in.rem} >= trial);
        if (take) begin
            stage_next.rem = stage_in.rem - trial[63:0];
            stage_next.root = stage_in.root | (32'd1 << BIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// File: design/isaf_div_cell.sv
// one quotient bit of three restoring dividers sharing a divisor
module isaf_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  isaf_pkg::div_stage_t stage_in,
    output isaf_pkg::div_stage_t stage_out
);
    import isaf_pkg::*;

    div_stage_t   stage_reg;
    div_stage_t   stage_next;
    logic [127:0] dbl [3];
    logic [2:0]   take;

    // shift remainder, subtract divisor where it fits
    always_comb begin
        stage_next = stage_in;
        for (int i = 0; i < 3; i++) begin
            dbl[i] = {stage_in.rem[i][126:0], 1'b0};
            take[i] = (dbl[i] >= {1'b0, stage_in.dsh});
            stage_next.rem[i] = take[i] ? (dbl[i] - {1'b0, stage_in.dsh}) : dbl[i];
            stage_next.quo[i] = {stage_in.quo[i][29:0], take[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (adv) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

// File: design/inverse_square_attractor_force_core.sv
// top level: attractor force pipeline with register port
//
// Input requests (s_valid/s_ready, s_data) carry an attractor and a body
// position in signed Q16.16; each gives exactly one result request
// (m_valid/m_ready, m_data) with the saturated force vector and in_range.
// Two registers sit on the APB-style port: attract_range at byte 0 and
// attract_strength at byte 4; write them only while the block is idle.
// Throughput is one request per cycle while results are accepted. From
// input acceptance to m_valid a request passes six arithmetic stages,
// a 32-cell square root chain, a 31-cell divider chain and the output
// register. The cell chains set the latency.
// The whole pipeline moves together; when the receiver holds m_ready low
// with a result waiting, every stage holds and s_ready drops, and bubbles
// inside the pipeline are not squeezed out while it waits.
// Reset clears all valid bits and loads range 2.0 and strength 10.0;
// s_ready stays low while reset is asserted.
module inverse_square_attractor_force_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  isaf_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output isaf_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import isaf_pkg::*;

    logic [31:0] range_reg;
    logic [31:0] strength_reg;
    logic [63:0] rsq_reg;
    logic        adv;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STRENGTH) ? strength_reg : range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= RANGE_RESET;
            strength_reg <= STRENGTH_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_RANGE:    range_reg <= pwdata;
                REG_STRENGTH: strength_reg <= pwdata;
                default:      range_reg <= range_reg;
            endcase
        end
    end

    // squared cutoff, follows the register
    always_ff @(posedge aclk) begin
        rsq_reg <= range_reg * range_reg;
    end

    assign adv = !m_valid || m_ready;
    assign s_ready = adv && aresetn;

    // stage 0: axis differences as sign and magnitude
    logic             v0_reg;
    logic [2:0]       neg0_reg;
    logic [2:0][31:0] mag0_reg;
    logic [31:0]      src [3];
    logic [31:0]      bod [3];
    logic [32:0]      diff [3];
    logic [2:0]       neg0_next;
    logic [2:0][31:0] mag0_next;

    always_comb begin
        src[0] = s_data.source_x;
        src[1] = s_data.source_y;
        src[2] = s_data.source_z;
        bod[0] = s_data.body_x;
        bod[1] = s_data.body_y;
        bod[2] = s_data.body_z;
        for (int i = 0; i < 3; i++) begin
            diff[i] = {src[i][31], src[i]} - {bod[i][31], bod[i]};
            neg0_next[i] = diff[i][32];
            mag0_next[i] = diff[i][32] ? 32'(33'd0 - diff[i]) : diff[i][31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_valid;
            neg0_reg <= neg0_next;
            mag0_reg <= mag0_next;
        end
    end

    // stage 1: squares
    logic             v1_reg;
    logic [2:0]       neg1_reg;
    logic [2:0][31:0] mag1_reg;
    logic [2:0][63:0] sq1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
            neg1_reg <= neg0_reg;
            mag1_reg <= mag0_reg;
            for (int i = 0; i < 3; i++) begin
                sq1_reg[i] <= mag0_reg[i] * mag0_reg[i];
            end
        end
    end

    // stage 2: sum of squares and range test, feeds the root chain
    sq_stage_t sq_chain [SQRT_STEPS+1];
    sq_stage_t sq_head_reg;
    logic [65:0] ssum;

    assign ssum = {2'b00, sq1_reg[0]} + {2'b00, sq1_reg[1]} + {2'b00, sq1_reg[2]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_head_reg.valid <= 1'b0;
        end else if (adv) begin
            sq_head_reg.valid <= v1_reg;
            sq_head_reg.rem <= ssum[63:0];
            sq_head_reg.root <= 32'd0;
            sq_head_reg.s <= ssum[63:0];
            sq_head_reg.ok <= (ssum != 66'd0) && (ssum < {2'b00, rsq_reg});
            sq_head_reg.neg <= neg1_reg;
            sq_head_reg.mag <= mag1_reg;
        end
    end

    assign sq_chain[0] = sq_head_reg;

    // square root chain, most significant root bit first
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        isaf_sqrt_cell #(
            .BIT(SQRT_STEPS - 1 - k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .stage_in (sq_chain[k]),
            .stage_out(sq_chain[k+1])
        );
    end

    // stage 3: partial products of the denominator and the numerators
    sq_stage_t        sq_tail;
    logic             v3_reg;
    logic             ok3_reg;
    logic [2:0]       neg3_reg;
    logic [63:0]      plo3_reg;
    logic [63:0]      phi3_reg;
    logic [2:0][63:0] num3_reg;

    assign sq_tail = sq_chain[SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= sq_tail.valid;
            ok3_reg <= sq_tail.ok;
            neg3_reg <= sq_tail.neg;
            plo3_reg <= sq_tail.s[31:0] * sq_tail.root;
            phi3_reg <= sq_tail.s[63:32] * sq_tail.root;
            for (int i = 0; i < 3; i++) begin
                num3_reg[i] <= strength_reg * sq_tail.mag[i];
            end
        end
    end

    // stage 4: denominator S * L
    logic             v4_reg;
    logic             ok4_reg;
    logic [2:0]       neg4_reg;
    logic [95:0]      den4_reg;
    logic [2:0][63:0] num4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (adv) begin
            v4_reg <= v3_reg;
            ok4_reg <= ok3_reg;
            neg4_reg <= neg3_reg;
            den4_reg <= {phi3_reg, 32'd0} + {32'd0, plo3_reg};
            num4_reg <= num3_reg;
        end
    end

    // stage 5: overflow check against divisor scaled by 2^31, loads the divider
    div_stage_t  div_chain [DIV_STEPS+1];
    div_stage_t  div_head_reg;
    logic [126:0] dsh5;
    logic [127:0] num5 [3];

    assign dsh5 = {den4_reg, 31'd0};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num5[i] = 128'(num4_reg[i]) << (2 * FRAC_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_head_reg.valid <= 1'b0;
        end else if (adv) begin
            div_head_reg.valid <= v4_reg;
            div_head_reg.ok <= ok4_reg;
            div_head_reg.neg <= neg4_reg;
            div_head_reg.dsh <= dsh5;
            for (int i = 0; i < 3; i++) begin
                div_head_reg.sat[i] <= (num5[i] >= {1'b0, dsh5});
                div_head_reg.rem[i] <= num5[i];
                div_head_reg.quo[i] <= 31'd0;
            end
        end
    end

    assign div_chain[0] = div_head_reg;

    // divider chain, one quotient bit per cell
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        isaf_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .stage_in (div_chain[k]),
            .stage_out(div_chain[k+1])
        );
    end

    // output register: sign, saturation and range gating
    div_stage_t  div_tail;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    logic [31:0] frc [3];

    assign div_tail = div_chain[DIV_STEPS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!div_tail.ok) begin
                frc[i] = 32'd0;
            end else if (div_tail.sat[i]) begin
                frc[i] = div_tail.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (div_tail.neg[i]) begin
                frc[i] = 32'd0 - {1'b0, div_tail.quo[i]};
            end else begin
                frc[i] = {1'b0, div_tail.quo[i]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_tail.valid;
            m_data_reg.force_x <= frc[0];
            m_data_reg.force_y <= frc[1];
            m_data_reg.force_z <= frc[2];
            m_data_reg.in_range <= div_tail.ok;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule
